// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. In synthesis they are empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on clk_i, disabled while rst_ni is low.
`define RDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Checked on clk_i at every edge, reset included.
`define RDR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define RDR_ASSERT(lbl, prop)
`define RDR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/rdr_pkg.sv -----
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared constants, register indexes and helpers of the stencil residual block.
// ----------------------------------------------------------------------------
`default_nettype none

package rdr_pkg;

  localparam int DATA_W         = 32;
  localparam int IDX_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [DATA_W-1:0] LEFT_BND_RST    = 32'd45511;
  localparam logic [DATA_W-1:0] RIGHT_BND_RST   = 32'd728178;
  localparam logic [DATA_W-1:0] REACT_SCALE_RST = 32'd10240;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_BND    = 2'd0,
    CFG_RIGHT_BND   = 2'd1,
    CFG_REACT_SCALE = 2'd2
  } cfg_idx_e;

  // Saturates a 33-bit two's complement value to 32 bits.
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Sign-extends a 32-bit value to 33 bits.
  function automatic logic [DATA_W:0] sext33(input logic [DATA_W-1:0] v);
    return {v[DATA_W-1], v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/reaction_diffusion_residual.sv -----
// ----------------------------------------------------------------------------
// reaction_diffusion_residual
// Streams grid values of a 1D reaction-diffusion problem and returns the
// nonlinear three-point residual of each point, using one bit-serial square
// root unit and one multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//  in       in         in_valid_i/in_ready_o   grid_value_i, is_last_i
//  out      out        out_valid_o/out_ready_i residual_o, point_index_o,
//                                              negative_root_o, last_result_o
//
//  Points 0 and 1 need no square root. An interior request runs through the
//  square root unit, which resolves one root bit per cycle, then through the
//  multiply and sum steps; a negative centre value skips the root.
//  The final point emits its second result from the emit step.
//  Input ready is low while a request is in work; a stalled output holds
//  the sequencer in its emit step. Reset returns the stream to point 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module reaction_diffusion_residual #(
  parameter int MAX_POINTS = rdr_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = rdr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rdr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rdr_pkg::DATA_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rdr_pkg::DATA_W-1:0]     grid_value_i,
  input  wire logic                           is_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [rdr_pkg::DATA_W-1:0]          residual_o,
  output logic [rdr_pkg::IDX_W-1:0]           point_index_o,
  output logic                                negative_root_o,
  output logic                                last_result_o
);

  localparam int DW  = rdr_pkg::DATA_W;
  localparam int CW  = $clog2(MAX_POINTS);
  localparam int XW  = DW - 1 + FRAC_BITS;
  localparam int RW  = (XW + 1) / 2;
  localparam int RMW = RW + 2;
  localparam int IW  = $clog2(RW + 1);
  localparam int PW  = DW + RW;
  localparam int RPW = PW + 1 - FRAC_BITS;
  localparam int SW  = ((RPW > 34) ? RPW : 34) + 2;
  localparam logic [PW:0] RND_ONE =
    {{(PW - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_MUL,
    S_SUM,
    S_EMIT
  } state_e;

  // Configuration registers.
  logic [DW-1:0] left_bnd_q, right_bnd_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bnd_q  <= rdr_pkg::LEFT_BND_RST;
      right_bnd_q <= rdr_pkg::RIGHT_BND_RST;
      scale_q     <= rdr_pkg::REACT_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rdr_pkg::CFG_LEFT_BND:    left_bnd_q  <= cfg_data_i;
        rdr_pkg::CFG_RIGHT_BND:   right_bnd_q <= cfg_data_i;
        rdr_pkg::CFG_REACT_SCALE: scale_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  state_e          state_q, state_d;
  logic [CW-1:0]   pc_q, pc_d;
  logic [DW-1:0]   left_q, left_d;
  logic [DW-1:0]   centre_q, centre_d;
  logic [DW-1:0]   c_q, c_d;
  logic [DW-1:0]   u_q, u_d;
  logic [DW:0]     lr_q, lr_d;
  logic [CW-1:0]   pt_q, pt_d;
  logic            neg_q, neg_d;
  logic [2*RW-1:0] x_q, x_d;
  logic [RMW-1:0]  rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [IW-1:0]   iter_q, iter_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [DW-1:0]   pres_q, pres_d;
  logic [CW-1:0]   pidx_q, pidx_d;
  logic            pneg_q, pneg_d;
  logic            plast_q, plast_d;
  logic            second_q, second_d;
  logic            out_valid_q, out_valid_d;
  logic [DW-1:0]   out_res_q, out_res_d;
  logic [CW-1:0]   out_idx_q, out_idx_d;
  logic            out_neg_q, out_neg_d;
  logic            out_last_q, out_last_d;

  // One step of the restoring square root.
  logic [RMW-1:0] rem_sh, trial;
  logic           take;

  assign rem_sh = {rem_q[RMW-3:0], x_q[2*RW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  // Rounded product and final sum.
  logic [PW:0]   rnd_sum;
  logic [SW-1:0] total;
  logic [SW-32:0] total_hi;
  logic [DW-1:0] total_sat;

  assign rnd_sum  = {1'b0, prod_q} + RND_ONE;
  assign total    = (SW'($signed(c_q)) <<< 1) - SW'($signed(lr_q))
                    + SW'(rnd_sum[PW:FRAC_BITS]);
  assign total_hi = total[SW-1:DW-1];
  assign total_sat = (&total_hi || ~|total_hi) ? total[DW-1:0] :
                     (total[SW-1] ? rdr_pkg::SAT_MIN : rdr_pkg::SAT_MAX);

  logic          last_pt;
  logic [DW-1:0] l_sel, r_sel;

  assign last_pt = is_last_i || (pc_q >= CW'(MAX_POINTS - 1));
  assign l_sel   = (pc_q == CW'(2)) ? left_bnd_q : left_q;
  assign r_sel   = (last_pt && (pc_q != CW'(2))) ? right_bnd_q : grid_value_i;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    left_d      = left_q;
    centre_d    = centre_q;
    c_d         = c_q;
    u_d         = u_q;
    lr_d        = lr_q;
    pt_d        = pt_q;
    neg_d       = neg_q;
    x_d         = x_q;
    rem_d       = rem_q;
    root_d      = root_q;
    iter_d      = iter_q;
    prod_d      = prod_q;
    pres_d      = pres_q;
    pidx_d      = pidx_q;
    pneg_d      = pneg_q;
    plast_d     = plast_q;
    second_d    = second_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_idx_d   = out_idx_q;
    out_neg_d   = out_neg_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (pc_q == '0) begin
            pres_d   = rdr_pkg::sat33(rdr_pkg::sext33(grid_value_i)
                                      - rdr_pkg::sext33(left_bnd_q));
            pidx_d   = '0;
            pneg_d   = 1'b0;
            plast_d  = 1'b0;
            second_d = 1'b0;
            pc_d     = CW'(1);
            state_d  = S_EMIT;
          end else if (pc_q == CW'(1)) begin
            centre_d = grid_value_i;
            pc_d     = CW'(2);
          end else begin
            c_d      = centre_q;
            u_d      = grid_value_i;
            lr_d     = rdr_pkg::sext33(l_sel) + rdr_pkg::sext33(r_sel);
            pt_d     = pc_q;
            pidx_d   = pc_q - CW'(1);
            second_d = last_pt;
            if (last_pt) begin
              pc_d = '0;
            end else begin
              left_d   = centre_q;
              centre_d = grid_value_i;
              pc_d     = pc_q + CW'(1);
            end
            root_d = '0;
            rem_d  = '0;
            iter_d = '0;
            x_d    = (2*RW)'({centre_q[DW-2:0], {FRAC_BITS{1'b0}}});
            if (centre_q[DW-1]) begin
              neg_d   = 1'b1;
              state_d = S_MUL;
            end else begin
              neg_d   = 1'b0;
              state_d = S_ROOT;
            end
          end
        end
      end
      S_ROOT: begin
        x_d = x_q << 2;
        if (take) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RW-2:0], 1'b0};
        end
        iter_d = iter_q + IW'(1);
        if (iter_q == IW'(RW - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = scale_q * root_q;
        state_d = S_SUM;
      end
      S_SUM: begin
        pres_d  = total_sat;
        pneg_d  = neg_q;
        plast_d = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = pres_q;
          out_idx_d   = pidx_q;
          out_neg_d   = pneg_q;
          out_last_d  = plast_q;
          if (second_q) begin
            pres_d   = rdr_pkg::sat33(rdr_pkg::sext33(u_q)
                                      - rdr_pkg::sext33(right_bnd_q));
            pidx_d   = pt_q;
            pneg_d   = 1'b0;
            plast_d  = 1'b1;
            second_d = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      left_q      <= '0;
      centre_q    <= '0;
      c_q         <= '0;
      u_q         <= '0;
      lr_q        <= '0;
      pt_q        <= '0;
      neg_q       <= 1'b0;
      x_q         <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      iter_q      <= '0;
      prod_q      <= '0;
      pres_q      <= '0;
      pidx_q      <= '0;
      pneg_q      <= 1'b0;
      plast_q     <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_idx_q   <= '0;
      out_neg_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      left_q      <= left_d;
      centre_q    <= centre_d;
      c_q         <= c_d;
      u_q         <= u_d;
      lr_q        <= lr_d;
      pt_q        <= pt_d;
      neg_q       <= neg_d;
      x_q         <= x_d;
      rem_q       <= rem_d;
      root_q      <= root_d;
      iter_q      <= iter_d;
      prod_q      <= prod_d;
      pres_q      <= pres_d;
      pidx_q      <= pidx_d;
      pneg_q      <= pneg_d;
      plast_q     <= plast_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_idx_q   <= out_idx_d;
      out_neg_q   <= out_neg_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign residual_o      = out_res_q;
  assign point_index_o   = rdr_pkg::IDX_W'(out_idx_q);
  assign negative_root_o = out_neg_q;
  assign last_result_o   = out_last_q;

  // A second grid point produces no result and leaves the block idle.
  `RDR_ASSERT(a_point1_silent, (in_valid_i && in_ready_o && pc_q == CW'(1)) |=> (state_q == S_IDLE))
  // The root iteration count never runs past the root width.
  `RDR_ASSERT(a_iter_range, (state_q == S_ROOT) |-> (iter_q < IW'(RW)))
  // A negative-root flag only comes with an interior point.
  `RDR_ASSERT(a_neg_interior, (out_valid_o && negative_root_o) |-> (!last_result_o && point_index_o != '0))
  // The final result is pending only after the point counter has wrapped.
  `RDR_ASSERT(a_last_wraps, (state_q == S_EMIT && plast_q && !second_q) |-> (pc_q == '0))

endmodule

`default_nettype wire
